>>> rtl/rsch_pkg.sv
// ---------------------------------------------------------------------------
// rsch_pkg
// Shared constants and the 16.16 rounding helper for the ray / sphere search.
// ---------------------------------------------------------------------------
package rsch_pkg;

   localparam int DEFAULT_DEPTH = 16;
   localparam int FX_W          = 32;
   localparam int ENTRY_W       = 4 * FX_W;
   localparam int COUNT_W       = 5;
   localparam int INDEX_W       = 4;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_RAY  = 1'b1;

   localparam logic [FX_W-1:0] T_FLOOR = 32'h0000_199A;
   localparam logic [FX_W-1:0] T_MAX   = 32'h7FFF_FFFF;
   localparam logic [FX_W-1:0] SIGN32  = 32'h8000_0000;

   // 16.16 product rounding: negative products step down by one, then bits 47:16 plus bit 15
   function automatic logic [FX_W-1:0] fx_round(input logic signed [63:0] prod);
      logic [63:0] p;
      p = prod - {63'd0, prod[63]};
      return p[47:16] + {31'd0, p[15]};
   endfunction

endpackage

>>> rtl/rsch_ram.sv
// ---------------------------------------------------------------------------
// rsch_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module rsch_ram #(
   parameter int WIDTH = rsch_pkg::ENTRY_W,
   parameter int DEPTH = rsch_pkg::DEFAULT_DEPTH,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/ray_sphere_closest_hit_top.sv
// ---------------------------------------------------------------------------
// ray_sphere_closest_hit_top
// Sphere table in a RAM; rays walk the table with one shared multiplier,
// a bit-serial square root and a bit-serial divider.
// ---------------------------------------------------------------------------
//  channel  | ports                        | handshake
//  request  | start, busy, req_*           | taken when start and not busy
//  response | rsp_valid, rsp_*             | one-cycle strobe, no back-pressure
//  csr      | csr_wr_en, csr_wr_data       | written when csr_wr_en
//
//  a load item's result appears the next cycle; busy stays low.
//  a ray runs d.d (three multiplies) and then, per sphere searched, a fetch,
//  operand setup, nine multiplies and a step; where the discriminant is
//  positive, a square root and one or two divider passes (one quotient bit a
//  cycle) come before the step. the result strobe follows the last step.
//  reset is synchronous and clears the count register and the sequencer;
//  the table is not cleared.
// ---------------------------------------------------------------------------
module ray_sphere_closest_hit_top #(
   parameter int TABLE_DEPTH = rsch_pkg::DEFAULT_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_opcode,
   input  logic [rsch_pkg::INDEX_W-1:0]  req_entry_index,
   input  logic signed [31:0]            req_center_x,
   input  logic signed [31:0]            req_center_y,
   input  logic signed [31:0]            req_center_z,
   input  logic signed [31:0]            req_radius,
   input  logic signed [31:0]            req_origin_x,
   input  logic signed [31:0]            req_origin_y,
   input  logic signed [31:0]            req_origin_z,
   input  logic signed [31:0]            req_dir_x,
   input  logic signed [31:0]            req_dir_y,
   input  logic signed [31:0]            req_dir_z,
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic [rsch_pkg::INDEX_W-1:0]  rsp_hit_index,
   output logic signed [31:0]            rsp_hit_distance,
   input  logic                          csr_wr_en,
   input  logic [rsch_pkg::COUNT_W-1:0]  csr_wr_data
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);

   localparam logic [3:0] STEP_DX  = 4'd0;
   localparam logic [3:0] STEP_DY  = 4'd1;
   localparam logic [3:0] STEP_DZ  = 4'd2;
   localparam logic [3:0] STEP_BX  = 4'd3;
   localparam logic [3:0] STEP_BY  = 4'd4;
   localparam logic [3:0] STEP_BZ  = 4'd5;
   localparam logic [3:0] STEP_CX  = 4'd6;
   localparam logic [3:0] STEP_CY  = 4'd7;
   localparam logic [3:0] STEP_CZ  = 4'd8;
   localparam logic [3:0] STEP_RR  = 4'd9;
   localparam logic [3:0] STEP_BB  = 4'd10;
   localparam logic [3:0] STEP_AC  = 4'd11;

   typedef enum logic [3:0] {
      ST_IDLE, ST_MUL, ST_RND, ST_FETCH, ST_OC, ST_SQRT, ST_SQRND,
      ST_DSET, ST_DIV, ST_CHK, ST_NEXT
   } state_type;

   state_type state_ff, state_in;
   logic [3:0]  step_ff, step_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic [CW-1:0] idx_ff, idx_in, n_ff, n_in, idx_next, n_calc;
   logic [rsch_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [31:0] org_ff [3], org_in [3];
   logic [31:0] dir_ff [3], dir_in [3];
   logic [31:0] oc_ff [3], oc_in [3];
   logic [31:0] rad_ff, rad_in, a_ff, a_in, b_ff, b_in, c_ff, c_in;
   logic [31:0] acc_ff, acc_in, s_ff, s_in, best_ff, best_in;
   logic signed [63:0] prod_ff, prod_in;
   logic signed [31:0] op_a, op_b;
   logic [47:0] sq_src_ff, sq_src_in;
   logic [25:0] sq_rem_ff, sq_rem_in;
   logic [23:0] sq_root_ff, sq_root_in;
   logic [48:0] dv_num_ff, dv_num_in;
   logic [31:0] dv_rem_ff, dv_rem_in, dv_den_ff, dv_den_in;
   logic [32:0] dv_q_ff, dv_q_in;
   logic        dv_neg_ff, dv_neg_in, second_ff, second_in, hit_ff, hit_in;
   logic [3:0]  found_ff, found_in;
   logic        rsp_valid_ff, rsp_valid_in, rsp_hit_ff, rsp_hit_in;
   logic [3:0]  rsp_index_ff, rsp_index_in;
   logic [31:0] rsp_dist_ff, rsp_dist_in;

   logic        accept, wr_en;
   logic [AW-1:0] wr_addr;
   logic [rsch_pkg::ENTRY_W-1:0] wr_data, rd_data;

   logic [31:0] rnd, acc_new, dx, magx, t_val;
   logic [27:0] sq_rem2, sq_trial;
   logic [32:0] dv_rem2;
   logic [33:0] dv_qp;
   logic        accept_t;

   assign accept  = start && !busy;
   assign busy    = (state_ff != ST_IDLE);
   assign wr_en   = accept && (req_opcode == rsch_pkg::OP_LOAD) &&
                    (int'(req_entry_index) < TABLE_DEPTH);
   assign wr_addr = AW'(req_entry_index);
   assign wr_data = {req_center_x, req_center_y, req_center_z, req_radius};

   rsch_ram #(
      .WIDTH (rsch_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff[AW-1:0]),
      .rd_data (rd_data)
   );

   // operand select for the shared multiplier
   always_comb begin
      case (step_ff)
         STEP_DX: begin op_a = dir_ff[0]; op_b = dir_ff[0]; end
         STEP_DY: begin op_a = dir_ff[1]; op_b = dir_ff[1]; end
         STEP_DZ: begin op_a = dir_ff[2]; op_b = dir_ff[2]; end
         STEP_BX: begin op_a = oc_ff[0];  op_b = dir_ff[0]; end
         STEP_BY: begin op_a = oc_ff[1];  op_b = dir_ff[1]; end
         STEP_BZ: begin op_a = oc_ff[2];  op_b = dir_ff[2]; end
         STEP_CX: begin op_a = oc_ff[0];  op_b = oc_ff[0];  end
         STEP_CY: begin op_a = oc_ff[1];  op_b = oc_ff[1];  end
         STEP_CZ: begin op_a = oc_ff[2];  op_b = oc_ff[2];  end
         STEP_RR: begin op_a = rad_ff;    op_b = rad_ff;    end
         STEP_BB: begin op_a = b_ff;      op_b = b_ff;      end
         STEP_AC: begin op_a = a_ff;      op_b = c_ff;      end
         default: begin op_a = '0;        op_b = '0;        end
      endcase
   end

   always_comb begin
      rnd = rsch_pkg::fx_round(prod_ff);
      case (step_ff)
         STEP_DX, STEP_BX, STEP_CX, STEP_BB: acc_new = rnd;
         STEP_RR, STEP_AC:                   acc_new = acc_ff - rnd;
         default:                            acc_new = acc_ff + rnd;
      endcase

      n_calc   = (int'(count_ff) < TABLE_DEPTH) ? CW'(count_ff) : CW'(TABLE_DEPTH);
      idx_next = idx_ff + CW'(1);

      sq_rem2  = {sq_rem_ff, sq_src_ff[47:46]};
      sq_trial = {2'b00, sq_root_ff, 2'b01};

      dx   = second_ff ? ((32'd0 - b_ff) + s_ff) : ((32'd0 - b_ff) - s_ff);
      magx = dx[31] ? (32'd0 - dx) : dx;

      dv_rem2 = {dv_rem_ff, dv_num_ff[48]};
      dv_qp   = {1'b0, dv_q_ff} + 34'd1;
      if (a_ff == 32'd0) begin
         t_val = rsch_pkg::SIGN32;
      end else if (dv_neg_ff) begin
         t_val = 32'd0 - dv_qp[32:1];
      end else begin
         t_val = dv_qp[32:1];
      end
      accept_t = ($signed(t_val) > $signed(rsch_pkg::T_FLOOR)) &&
                 ($signed(t_val) < $signed(best_ff));
   end

   always_comb begin
      state_in   = state_ff;
      step_in    = step_ff;
      cnt_in     = cnt_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      count_in   = csr_wr_en ? csr_wr_data : count_ff;
      org_in     = org_ff;
      dir_in     = dir_ff;
      oc_in      = oc_ff;
      rad_in     = rad_ff;
      a_in       = a_ff;
      b_in       = b_ff;
      c_in       = c_ff;
      acc_in     = acc_ff;
      s_in       = s_ff;
      best_in    = best_ff;
      prod_in    = prod_ff;
      sq_src_in  = sq_src_ff;
      sq_rem_in  = sq_rem_ff;
      sq_root_in = sq_root_ff;
      dv_num_in  = dv_num_ff;
      dv_rem_in  = dv_rem_ff;
      dv_den_in  = dv_den_ff;
      dv_q_in    = dv_q_ff;
      dv_neg_in  = dv_neg_ff;
      second_in  = second_ff;
      hit_in     = hit_ff;
      found_in   = found_ff;
      rsp_valid_in = 1'b0;
      rsp_hit_in   = rsp_hit_ff;
      rsp_index_in = rsp_index_ff;
      rsp_dist_in  = rsp_dist_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_opcode == rsch_pkg::OP_LOAD || n_calc == CW'(0)) begin
                  rsp_valid_in = 1'b1;
                  rsp_hit_in   = 1'b0;
                  rsp_index_in = '0;
                  rsp_dist_in  = rsch_pkg::T_MAX;
               end else begin
                  org_in   = '{req_origin_x, req_origin_y, req_origin_z};
                  dir_in   = '{req_dir_x, req_dir_y, req_dir_z};
                  n_in     = n_calc;
                  idx_in   = '0;
                  best_in  = rsch_pkg::T_MAX;
                  found_in = '0;
                  hit_in   = 1'b0;
                  step_in  = STEP_DX;
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            prod_in  = op_a * op_b;
            state_in = ST_RND;
         end
         ST_RND: begin
            acc_in  = acc_new;
            step_in = step_ff + 4'd1;
            state_in = ST_MUL;
            case (step_ff)
               STEP_DZ: begin
                  a_in     = acc_new;
                  state_in = ST_FETCH;
               end
               STEP_BZ: b_in = acc_new;
               STEP_RR: c_in = acc_new;
               STEP_AC: begin
                  if ($signed(acc_new) > 32'sd0) begin
                     sq_src_in  = {acc_new, 16'd0};
                     sq_rem_in  = '0;
                     sq_root_in = '0;
                     cnt_in     = '0;
                     state_in   = ST_SQRT;
                  end else begin
                     state_in = ST_NEXT;
                  end
               end
               default: ;
            endcase
         end
         ST_FETCH: begin
            // read address is idx_ff; data lands next cycle
            second_in = 1'b0;
            state_in  = ST_OC;
         end
         ST_OC: begin
            oc_in[0] = org_ff[0] - rd_data[127:96];
            oc_in[1] = org_ff[1] - rd_data[95:64];
            oc_in[2] = org_ff[2] - rd_data[63:32];
            rad_in   = rd_data[31:0];
            step_in  = STEP_BX;
            state_in = ST_MUL;
         end
         ST_SQRT: begin
            sq_src_in = {sq_src_ff[45:0], 2'b00};
            if (sq_rem2 >= sq_trial) begin
               sq_rem_in  = 26'(sq_rem2 - sq_trial);
               sq_root_in = {sq_root_ff[22:0], 1'b1};
            end else begin
               sq_rem_in  = sq_rem2[25:0];
               sq_root_in = {sq_root_ff[22:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd23) begin
               state_in = ST_SQRND;
            end
         end
         ST_SQRND: begin
            // round up when the remainder exceeds the root
            s_in = {8'd0, sq_root_ff} +
                   {31'd0, (sq_rem_ff > {2'b00, sq_root_ff})};
            state_in = ST_DSET;
         end
         ST_DSET: begin
            dv_num_in = {magx, 17'd0};
            dv_den_in = a_ff[31] ? (32'd0 - a_ff) : a_ff;
            dv_neg_in = dx[31] ^ a_ff[31];
            dv_rem_in = '0;
            dv_q_in   = '0;
            cnt_in    = '0;
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            dv_num_in = {dv_num_ff[47:0], 1'b0};
            if (dv_rem2 >= {1'b0, dv_den_ff}) begin
               dv_rem_in = 32'(dv_rem2 - {1'b0, dv_den_ff});
               dv_q_in   = {dv_q_ff[31:0], 1'b1};
            end else begin
               dv_rem_in = dv_rem2[31:0];
               dv_q_in   = {dv_q_ff[31:0], 1'b0};
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'd48) begin
               state_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (accept_t) begin
               best_in  = t_val;
               found_in = 4'(idx_ff);
               hit_in   = 1'b1;
               state_in = ST_NEXT;
            end else if (!second_ff) begin
               second_in = 1'b1;
               state_in  = ST_DSET;
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_NEXT: begin
            idx_in = idx_next;
            if (idx_next == n_ff) begin
               rsp_valid_in = 1'b1;
               rsp_hit_in   = hit_ff;
               rsp_index_in = hit_ff ? found_ff : 4'd0;
               rsp_dist_in  = best_ff;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_FETCH;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff      <= step_in;
      cnt_ff       <= cnt_in;
      idx_ff       <= idx_in;
      n_ff         <= n_in;
      org_ff       <= org_in;
      dir_ff       <= dir_in;
      oc_ff        <= oc_in;
      rad_ff       <= rad_in;
      a_ff         <= a_in;
      b_ff         <= b_in;
      c_ff         <= c_in;
      acc_ff       <= acc_in;
      s_ff         <= s_in;
      best_ff      <= best_in;
      prod_ff      <= prod_in;
      sq_src_ff    <= sq_src_in;
      sq_rem_ff    <= sq_rem_in;
      sq_root_ff   <= sq_root_in;
      dv_num_ff    <= dv_num_in;
      dv_rem_ff    <= dv_rem_in;
      dv_den_ff    <= dv_den_in;
      dv_q_ff      <= dv_q_in;
      dv_neg_ff    <= dv_neg_in;
      second_ff    <= second_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_index_ff <= rsp_index_in;
      rsp_dist_ff  <= rsp_dist_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_hit_index    = rsp_index_ff;
   assign rsp_hit_distance = rsp_dist_ff;

`ifndef SYNTHESIS
   a_load_answers: assert property (@(posedge clock) disable iff (reset)
      accept && (req_opcode == rsch_pkg::OP_LOAD) |=> rsp_valid)
      else $error("load item gave no result");

   a_hit_above_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_hit_distance > $signed(rsch_pkg::T_FLOOR))
      else $error("hit reported at or below the floor");

   a_miss_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_distance == $signed(rsch_pkg::T_MAX) &&
                                rsp_hit_index == 4'd0)
      else $error("miss with a distance or index");

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while still busy");
`endif

endmodule
